// ===== src/a2i_pkg.sv =====
// Shared types, character codes and digit decoding for the ASCII to integer parser.
`default_nettype none
package a2i_pkg;

  typedef enum logic [2:0] {
    PH_SPACE,
    PH_SIGN,
    PH_ZERO,
    PH_DIGITS,
    PH_STOP
  } phase_t;

  typedef enum logic [1:0] {
    RADIX_DEC,
    RADIX_OCT,
    RADIX_HEX
  } radix_t;

  typedef struct packed {
    phase_t     phase;
    radix_t     radix;
    logic       minus;
    logic [7:0] stopped_at;
  } ctl_t;

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_ONE   = 8'h31;
  localparam logic [7:0] CH_SEVEN = 8'h37;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_UP_A  = 8'h41;
  localparam logic [7:0] CH_UP_X  = 8'h58;
  localparam logic [7:0] CH_UP_Z  = 8'h5A;
  localparam logic [7:0] CH_LO_A  = 8'h61;
  localparam logic [7:0] CH_LO_X  = 8'h78;
  localparam logic [7:0] CH_LO_Z  = 8'h7A;

  localparam logic [5:0] NOT_DIGIT = 6'd63;
  localparam logic [5:0] BASE_DEC  = 6'd10;
  localparam logic [5:0] BASE_OCT  = 6'd8;
  localparam logic [5:0] BASE_HEX  = 6'd16;

  // Digit value of a character, letters case-insensitive, NOT_DIGIT otherwise.
  function automatic logic [5:0] digit_of(input logic [7:0] c);
    logic [7:0] d;
    begin
      d = 8'(NOT_DIGIT);
      if (c >= CH_ZERO && c <= CH_NINE) begin
        d = c - CH_ZERO;
      end else if (c >= CH_UP_A && c <= CH_UP_Z) begin
        d = c - CH_UP_A + 8'd10;
      end else if (c >= CH_LO_A && c <= CH_LO_Z) begin
        d = c - CH_LO_A + 8'd10;
      end
      return d[5:0];
    end
  endfunction

  function automatic logic is_blank(input logic [7:0] c);
    return (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
  endfunction

endpackage
`default_nettype wire

// ===== src/a2i_step.sv =====
// Per-character next-state logic and result formatting of the parser.
`default_nettype none
module a2i_step
  import a2i_pkg::*;
#(
  parameter int VALUE_BITS = 32
) (
  input  wire logic [7:0]            ch,
  input  wire ctl_t                  ctl,
  input  wire logic [VALUE_BITS-1:0] accum,
  output ctl_t                       ctl_next,
  output logic [VALUE_BITS-1:0]      accum_next,
  output logic [31:0]                unsigned_value,
  output logic [31:0]                signed_value,
  output logic                       negative,
  output logic [7:0]                 stop_char
);

  localparam int EXT_BITS = (VALUE_BITS > 32) ? VALUE_BITS : 32;

  logic                  take;
  radix_t                take_radix;
  logic [5:0]            base;
  logic [5:0]            digit;
  logic                  is_stop;
  logic [VALUE_BITS-1:0] mul;
  logic [VALUE_BITS-1:0] sval;
  logic [EXT_BITS-1:0]   v_ext;
  logic [EXT_BITS-1:0]   s_ext;
  logic [31:0]           s32;

  // Which action the character calls for in the current phase.
  always_comb begin
    take       = 1'b0;
    take_radix = RADIX_DEC;
    ctl_next   = ctl;
    case (ctl.phase)
      PH_SPACE: begin
        if (is_blank(ch)) begin
          ctl_next = ctl;
        end else if (ch == CH_MINUS) begin
          ctl_next.minus = 1'b1;
          ctl_next.phase = PH_SIGN;
        end else if (ch == CH_PLUS) begin
          ctl_next.phase = PH_SIGN;
        end else if (ch == CH_ZERO) begin
          ctl_next.phase = PH_ZERO;
        end else begin
          take = 1'b1;
        end
      end
      PH_SIGN: begin
        if (ch == CH_ZERO) begin
          ctl_next.phase = PH_ZERO;
        end else begin
          take = 1'b1;
        end
      end
      PH_ZERO: begin
        if (ch == CH_LO_X || ch == CH_UP_X) begin
          ctl_next.radix = RADIX_HEX;
          ctl_next.phase = PH_DIGITS;
        end else if (ch >= CH_ONE && ch <= CH_SEVEN) begin
          take       = 1'b1;
          take_radix = RADIX_OCT;
        end else begin
          take = 1'b1;
        end
      end
      PH_DIGITS: begin
        take       = 1'b1;
        take_radix = ctl.radix;
      end
      default: begin
        ctl_next.phase = PH_STOP;
      end
    endcase
    if (take) begin
      ctl_next.radix = take_radix;
      if (is_stop) begin
        ctl_next.phase      = PH_STOP;
        ctl_next.stopped_at = ch;
      end else begin
        ctl_next.phase = PH_DIGITS;
      end
    end
  end

  // Digit accumulation: the constant bases reduce to shifts and adds.
  always_comb begin
    digit = digit_of(ch);
    case (take_radix)
      RADIX_HEX: begin
        base = BASE_HEX;
        mul  = accum << 4;
      end
      RADIX_OCT: begin
        base = BASE_OCT;
        mul  = accum << 3;
      end
      default: begin
        base = BASE_DEC;
        mul  = (accum << 3) + (accum << 1);
      end
    endcase
    is_stop    = digit >= base;
    accum_next = accum;
    if (take && !is_stop) begin
      accum_next = mul + VALUE_BITS'(digit);
    end
  end

  // Result fields, formed from the state that a NUL finds.
  always_comb begin
    sval           = accum[VALUE_BITS-1] ? '0 : accum;
    v_ext          = EXT_BITS'(accum);
    s_ext          = EXT_BITS'(sval);
    s32            = ctl.minus ? (32'd0 - s_ext[31:0]) : s_ext[31:0];
    unsigned_value = ctl.minus ? 32'd0 : v_ext[31:0];
    signed_value   = s32;
    negative       = ctl.minus;
    stop_char      = (ctl.phase == PH_STOP) ? ctl.stopped_at : CH_NUL;
  end

endmodule
`default_nettype wire

// ===== src/ascii_to_integer_parser.sv =====
// Top level of the ASCII to integer parser: stream ports, parse state and result register.
// A NUL request is accepted and its result shows on m_tvalid in the next cycle.
// Throughput: one character per cycle; the per-character state update is one pass of
// shift-and-add logic between the state registers.
// A result waits in a single output register; input stalls only while it is held.
// Reset (rst, synchronous, active high) clears the parse state and drops m_tvalid.
`default_nettype none
module ascii_to_integer_parser
  import a2i_pkg::*;
#(
  parameter int VALUE_BITS = 32
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [7:0]  s_tdata,   // [7:0] ch
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [79:0]      m_tdata    // [31:0] unsigned_value, [63:32] signed_value,
                                      // [64] negative, [72:65] stop_char, [79:73] zero
);

  localparam ctl_t CTL_RESET = '{phase: PH_SPACE, radix: RADIX_DEC, minus: 1'b0,
                                 stopped_at: 8'd0};

  ctl_t                  ctl;
  ctl_t                  ctl_next;
  logic [VALUE_BITS-1:0] accum;
  logic [VALUE_BITS-1:0] accum_next;
  logic [31:0]           unsigned_value;
  logic [31:0]           signed_value;
  logic                  negative;
  logic [7:0]            stop_char;
  logic                  in_take;
  logic                  is_end;

  a2i_step #(
    .VALUE_BITS(VALUE_BITS)
  ) u_step (
    .ch            (s_tdata),
    .ctl           (ctl),
    .accum         (accum),
    .ctl_next      (ctl_next),
    .accum_next    (accum_next),
    .unsigned_value(unsigned_value),
    .signed_value  (signed_value),
    .negative      (negative),
    .stop_char     (stop_char)
  );

  // The output register frees up in the same cycle its result is taken, so a new
  // request can be accepted every cycle while results drain.
  assign s_tready = !m_tvalid || m_tready;
  assign in_take  = s_tvalid && s_tready;
  assign is_end   = (s_tdata == CH_NUL);

  // Parse state. A NUL closes the string and restores the reset state for the next one.
  always_ff @(posedge clk) begin
    if (rst) begin
      ctl   <= CTL_RESET;
      accum <= '0;
    end else if (in_take) begin
      if (is_end) begin
        ctl   <= CTL_RESET;
        accum <= '0;
      end else begin
        ctl   <= ctl_next;
        accum <= accum_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (in_take && is_end) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  // Result payload carries no reset; it is qualified by m_tvalid.
  always_ff @(posedge clk) begin
    if (in_take && is_end) begin
      m_tdata <= {7'd0, stop_char, negative, signed_value, unsigned_value};
    end
  end

endmodule
`default_nettype wire

// ===== dv/tb_ascii_to_integer_parser.sv =====
// Self-checking testbench for the ASCII to integer parser stream block.
module tb_ascii_to_integer_parser;
  import a2i_pkg::*;

  localparam int IDLE_LIMIT = 2000;
  localparam int MAX_SHOWN = 10;

  // One parsed number as the block reports it.
  typedef struct packed {
    logic [7:0]  stop;
    logic        neg;
    logic [31:0] sval;
    logic [31:0] uval;
  } number_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata = CH_NUL;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [79:0] m_tdata;

  // Shadow copy of the parse state, advanced on every accepted request.
  phase_t      pr_phase = PH_SPACE;
  radix_t      pr_radix = RADIX_DEC;
  logic [31:0] pr_acc = '0;
  logic        pr_minus = 1'b0;
  logic [7:0]  pr_stop = CH_NUL;

  number_t expected_numbers[$];
  int      error_count = 0;
  int      chars_sent = 0;
  int      idle_cycles = 0;
  int      stall_left = 0;
  bit      sender_gaps_on = 1'b1;
  bit      sink_stalls_on = 1'b1;

  ascii_to_integer_parser u_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Mostly no gap, often a short one, now and then a long one.
  function automatic int idle_len(input bit enabled);
    int r;
    if (!enabled) return 0;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic int char_value(input logic [7:0] c);
    if (c >= CH_ZERO && c <= CH_NINE) return c - CH_ZERO;
    if (c >= CH_UP_A && c <= CH_UP_Z) return c - CH_UP_A + 10;
    if (c >= CH_LO_A && c <= CH_LO_Z) return c - CH_LO_A + 10;
    return NOT_DIGIT;
  endfunction

  function automatic bit is_ws(input logic [7:0] c);
    return (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
  endfunction

  function automatic logic [7:0] digit_char(input int v);
    if (v < 10) return 8'(CH_ZERO + v);
    return 8'(($urandom_range(0, 1) ? CH_UP_A : CH_LO_A) + v - 10);
  endfunction

  task automatic clear_parse();
    pr_phase = PH_SPACE;
    pr_radix = RADIX_DEC;
    pr_acc = '0;
    pr_minus = 1'b0;
    pr_stop = CH_NUL;
  endtask

  // Folds one byte into the running value, or freezes the parse on a non-digit of the radix.
  task automatic accum_digit(input logic [7:0] c);
    int base;
    int d;
    case (pr_radix)
      RADIX_HEX: base = BASE_HEX;
      RADIX_OCT: base = BASE_OCT;
      default:   base = BASE_DEC;
    endcase
    d = char_value(c);
    pr_phase = PH_DIGITS;
    if (d >= base) begin
      pr_stop = c;
      pr_phase = PH_STOP;
    end else begin
      pr_acc = 32'(pr_acc * base + d);
    end
  endtask

  // Advances the shadow state by one accepted byte; a NUL queues the expected number.
  task automatic parse_char(input logic [7:0] c);
    number_t want;
    if (c == CH_NUL) begin
      want.uval = pr_minus ? '0 : pr_acc;
      want.sval = pr_acc[31] ? '0 : pr_acc;
      if (pr_minus) want.sval = -want.sval;
      want.neg = pr_minus;
      want.stop = (pr_phase == PH_STOP) ? pr_stop : CH_NUL;
      expected_numbers.push_back(want);
      clear_parse();
      return;
    end
    case (pr_phase)
      PH_SPACE: begin
        if (!is_ws(c)) begin
          if (c == CH_MINUS) begin
            pr_minus = 1'b1;
            pr_phase = PH_SIGN;
          end else if (c == CH_PLUS) begin
            pr_phase = PH_SIGN;
          end else if (c == CH_ZERO) begin
            pr_phase = PH_ZERO;
          end else begin
            pr_radix = RADIX_DEC;
            accum_digit(c);
          end
        end
      end
      PH_SIGN: begin
        if (c == CH_ZERO) begin
          pr_phase = PH_ZERO;
        end else begin
          pr_radix = RADIX_DEC;
          accum_digit(c);
        end
      end
      PH_ZERO: begin
        if (c == CH_LO_X || c == CH_UP_X) begin
          pr_radix = RADIX_HEX;
          pr_phase = PH_DIGITS;
        end else if (c >= CH_ONE && c <= CH_SEVEN) begin
          pr_radix = RADIX_OCT;
          accum_digit(c);
        end else begin
          pr_radix = RADIX_DEC;
          accum_digit(c);
        end
      end
      PH_DIGITS: accum_digit(c);
      default:   pr_phase = PH_STOP;
    endcase
  endtask

  // Sends one byte as a request, after a random gap, and predicts on acceptance.
  task automatic send_char(input logic [7:0] c);
    int gap;
    gap = idle_len(sender_gaps_on);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= c;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    parse_char(c);
    chars_sent++;
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_char(s[i]);
    send_char(CH_NUL);
  endtask

  // A plausible number: blanks, sign, base prefix, digits, maybe trailing junk.
  task automatic send_random_number();
    int nblank;
    int form;
    int base;
    int ndig;
    nblank = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0;
    repeat (nblank) send_char($urandom_range(0, 6) == 0 ? CH_SPACE : 8'($urandom_range(9, 13)));
    case ($urandom_range(0, 3))
      0: send_char(CH_MINUS);
      1: send_char(CH_PLUS);
      default: ;
    endcase
    form = $urandom_range(0, 9);
    base = BASE_DEC;
    if (form >= 5) send_char(CH_ZERO);
    if (form >= 7) begin
      send_char($urandom_range(0, 1) ? CH_LO_X : CH_UP_X);
      base = BASE_HEX;
    end else if (form >= 5) begin
      base = BASE_OCT;
    end
    ndig = ($urandom_range(0, 9) == 0) ? $urandom_range(11, 14) : $urandom_range(0, 10);
    repeat (ndig) send_char(digit_char($urandom_range(0, base - 1)));
    if ($urandom_range(0, 9) < 3) begin
      repeat ($urandom_range(1, 3)) send_char(8'($urandom_range(1, 255)));
    end
    send_char(CH_NUL);
  endtask

  task automatic test_blank_and_empty();
    send_text("");
    send_text(" \t\n\013\014\015");
    send_text("\t 42");
  endtask

  task automatic test_signs();
    send_text("+");
    send_text("-");
    send_text("-17");
    send_text("- 5");
    send_text("-+3");
  endtask

  task automatic test_radix_prefixes();
    send_text("0777");
    send_text("09");
    send_text("0 1");
    send_text("0x");
    send_text("0X1fF");
    send_text("0xg");
    send_text("0xFFFFFFFF");
  endtask

  task automatic test_overflow_and_sign_bit();
    send_text("4294967296");
    send_text("2147483648");
    send_text("-2147483647");
    send_text("99999999999");
  endtask

  task automatic test_stop_chars();
    send_text("12abc");
    send_text("zZ");
    send_text("12\2003");
    send_text("\377");
    send_text("7.5");
  endtask

  task automatic test_random_numbers(input int target);
    int goal;
    goal = chars_sent + target;
    while (chars_sent < goal) send_random_number();
  endtask

  // Junk strings, weighted toward characters that steer the parse.
  task automatic test_random_noise(input int target);
    int goal;
    logic [7:0] c;
    goal = chars_sent + target;
    while (chars_sent < goal) begin
      repeat ($urandom_range(0, 6)) begin
        case ($urandom_range(0, 7))
          0: c = CH_ZERO;
          1: c = CH_LO_X;
          2: c = $urandom_range(0, 1) ? CH_MINUS : CH_PLUS;
          3: c = CH_SPACE;
          default: c = 8'($urandom_range(1, 255));
        endcase
        send_char(c);
      end
      send_char(CH_NUL);
    end
  endtask

  // A stretch with neither side idling, so requests and results run back to back.
  task automatic test_back_to_back(input int target);
    sender_gaps_on = 1'b0;
    sink_stalls_on = 1'b0;
    test_random_numbers(target);
    sender_gaps_on = 1'b1;
    sink_stalls_on = 1'b1;
  endtask

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      error_count++;
      if (error_count <= MAX_SHOWN)
        $display("mismatch in %s: expected %h, got %h", name, want, got);
    end
  endtask

  // Checks each accepted result against the oldest prediction and drives m_tready.
  always @(posedge clk) begin : result_check
    number_t want;
    int n;
    if (rst) begin
      m_tready <= 1'b0;
      stall_left = 0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (expected_numbers.size() == 0) begin
          error_count++;
          if (error_count <= MAX_SHOWN)
            $display("unexpected result: %h", m_tdata);
        end else begin
          want = expected_numbers.pop_front();
          check_field("unsigned_value", want.uval, m_tdata[31:0]);
          check_field("signed_value", want.sval, m_tdata[63:32]);
          check_field("negative", 32'(want.neg), 32'(m_tdata[64]));
          check_field("stop_char", 32'(want.stop), 32'(m_tdata[72:65]));
        end
      end
      if (stall_left > 0) begin
        m_tready <= 1'b0;
        stall_left--;
      end else begin
        n = idle_len(sink_stalls_on);
        m_tready <= (n == 0);
        if (n > 0) stall_left = n - 1;
      end
    end
  end

  // Ends the run if neither side moves a request or result for too long.
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("tb_ascii_to_integer_parser: FAIL");
        $finish;
      end
    end
  end

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_blank_and_empty();
    test_signs();
    test_radix_prefixes();
    test_overflow_and_sign_bit();
    test_stop_chars();
    test_random_numbers(800);
    test_back_to_back(200);
    test_random_noise(250);
    test_random_numbers(600);
    s_tvalid <= 1'b0;
    while (expected_numbers.size() != 0) @(posedge clk);
    repeat (5) @(posedge clk);
    if (error_count == 0 && expected_numbers.size() == 0) begin
      $display("tb_ascii_to_integer_parser: PASS");
    end else begin
      $display("tb_ascii_to_integer_parser: FAIL");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
src/a2i_pkg.sv
src/a2i_step.sv
src/ascii_to_integer_parser.sv
dv/tb_ascii_to_integer_parser.sv
